// ----- src/tcrw_pkg.sv -----
// Shared types and constants for the TCP Reno congestion window unit.
package tcrw_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic {
    OP_ACK     = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NEW_ACK   = 2'd0,
    EV_DUP_ACK   = 2'd1,
    EV_STALE_ACK = 2'd2,
    EV_TIMEOUT   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_SIZE      = 8'd0,
    REG_INITIAL_THRESHOLD = 8'd1
  } reg_idx_t;

  localparam logic [15:0] SEG_SIZE_RST = 16'd1024;
  localparam logic [31:0] INIT_THR_RST = 32'd65535;
  localparam logic [7:0]  DUP_MAX      = 8'd255;
  localparam logic [7:0]  DUP_FAST     = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_REPAIR,
    ST_ALLOW,
    ST_HEAD,
    ST_POST
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [30:0] ack_number;
    logic [31:0] outstanding_bytes;
    logic [15:0] head_segment_size;
  } event_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [31:0] send_allowance;
    logic        retransmit_request;
    logic [31:0] window_now;
    logic [31:0] threshold_now;
    logic [7:0]  duplicate_count;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/tcrw_event_if.sv -----
// Event channel: ack and timeout words into the unit.
interface tcrw_event_if import tcrw_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tcrw_result_if.sv -----
// Result channel: window report words out of the unit.
interface tcrw_result_if import tcrw_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tcrw_cfg_if.sv -----
// Configuration write channel.
interface tcrw_cfg_if import tcrw_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tcrw_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module tcrw_div import tcrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output div_stat_t   stat,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        take;

  always_comb begin
    rem_sh   = {rem, quo[31]};
    rem_diff = rem_sh - {1'b0, dvs};
    take     = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? rem_diff[31:0] : rem_sh[31:0];
      quo <= {quo[30:0], take};
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = quo;

endmodule

// ----- src/tcp_reno_congestion_window_unit.sv -----
// Top level: TCP Reno congestion window control with an iterative divider.
// After accept, timeouts, stale and plain duplicate acks pass from EVAL to POST; a new ack that
// needs no division adds ALLOW, a fast retransmit goes REPAIR, ALLOW and HEAD, and congestion
// avoidance waits in DIV for the 32-step divider loop. A new word is taken only once the result
// is raised, later while an earlier result waits.
// Synchronous reset loads window and allowance with 1024 and threshold with 65535.
module tcp_reno_congestion_window_unit import tcrw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tcrw_event_if.sink    events,
  tcrw_result_if.source results,
  tcrw_cfg_if.sink      cfg
);

  state_t      state;
  state_t      state_next;

  logic [15:0] seg_size;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic [30:0] last_ack;
  logic [7:0]  dup_cnt;
  logic        in_fr;
  logic [31:0] allowance;

  op_t         op;
  logic [30:0] ack;
  logic [31:0] queued;
  logic [15:0] head;
  kind_t       kind;
  logic        resend;

  logic        out_valid;
  result_t     out_data;

  logic        div_start;
  div_stat_t   div_stat;
  logic [31:0] quotient;
  logic [31:0] sq;

  logic        is_new;
  logic        is_dup;
  logic        slow;
  logic [7:0]  dup_inc;
  logic        fr_fire;
  logic [31:0] seg_ext;
  logic [31:0] backoff;
  logic [31:0] seg3;
  logic        cfg_wr;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  always_comb begin
    seg_ext = {16'd0, seg_size};
    sq      = seg_ext * seg_ext;
    seg3    = {15'd0, seg_size, 1'b0} + seg_ext;
    backoff = ((cwnd >> 1) > {15'd0, seg_size, 1'b0}) ? (cwnd >> 1)
                                                       : {15'd0, seg_size, 1'b0};
    is_new  = (op == OP_ACK) && (ack > last_ack);
    is_dup  = (op == OP_ACK) && (ack == last_ack);
    slow    = cwnd < ssthresh;
    dup_inc = (dup_cnt < DUP_MAX) ? dup_cnt + 8'd1 : DUP_MAX;
    fr_fire = is_dup && (dup_inc == DUP_FAST) && (queued != 32'd0);
    cfg_wr  = cfg.valid && cfg.ready;
  end

  tcrw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sq),
    .divisor  (cwnd),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    events.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        events.ready = 1'b1;
        if (events.valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (op == OP_TIMEOUT) begin
          state_next = ST_POST;
        end else if (is_new) begin
          if (!in_fr && !slow && cwnd != 32'd0) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_ALLOW;
          end
        end else if (fr_fire) begin
          state_next = ST_REPAIR;
        end else begin
          state_next = ST_POST;
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_ALLOW;
      end
      ST_REPAIR: state_next = ST_ALLOW;
      ST_ALLOW:  state_next = resend ? ST_HEAD : ST_POST;
      ST_HEAD:   state_next = ST_POST;
      ST_POST: begin
        if (!out_valid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // window state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size  <= SEG_SIZE_RST;
      cwnd      <= {16'd0, SEG_SIZE_RST};
      ssthresh  <= INIT_THR_RST;
      last_ack  <= '0;
      dup_cnt   <= '0;
      in_fr     <= 1'b0;
      allowance <= {16'd0, SEG_SIZE_RST};
      out_valid <= 1'b0;
    end else begin
      if (state == ST_POST && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_EVAL: begin
          if (op == OP_TIMEOUT) begin
            allowance <= seg_ext;
            ssthresh  <= backoff;
            cwnd      <= seg_ext;
          end else if (is_new) begin
            dup_cnt  <= '0;
            last_ack <= ack;
            if (in_fr) begin
              cwnd  <= ssthresh;
              in_fr <= 1'b0;
            end else if (slow) begin
              cwnd <= sat_add(cwnd, seg_ext);
            end else if (cwnd == 32'd0) begin
              cwnd <= sq;
            end
          end else if (is_dup) begin
            dup_cnt <= dup_inc;
            if (fr_fire) begin
              in_fr    <= 1'b1;
              ssthresh <= backoff;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) cwnd <= sat_add(cwnd, quotient);
        end
        ST_REPAIR: cwnd <= sat_add(ssthresh, seg3);
        ST_ALLOW:  allowance <= floor_sub(cwnd, queued);
        ST_HEAD:   allowance <= floor_sub(allowance, {16'd0, head});
        default: ;
      endcase
      if (cfg_wr) begin
        case (cfg.data.index)
          REG_SEGMENT_SIZE: begin
            seg_size  <= cfg.data.value[15:0];
            cwnd      <= {16'd0, cfg.data.value[15:0]};
            allowance <= {16'd0, cfg.data.value[15:0]};
          end
          REG_INITIAL_THRESHOLD: begin
            ssthresh <= cfg.data.value;
          end
          default: ;
        endcase
      end
    end
  end

  // captured event word, event kind, result word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && events.valid) begin
      op     <= events.data.operation;
      ack    <= events.data.ack_number;
      queued <= events.data.outstanding_bytes;
      head   <= events.data.head_segment_size;
    end
    if (state == ST_EVAL) begin
      resend <= fr_fire;
      if (op == OP_TIMEOUT) kind <= EV_TIMEOUT;
      else if (is_new)      kind <= EV_NEW_ACK;
      else if (is_dup)      kind <= EV_DUP_ACK;
      else                  kind <= EV_STALE_ACK;
    end
    if (state == ST_POST && (!out_valid || results.ready)) begin
      out_data.event_kind         <= kind;
      out_data.send_allowance     <= allowance;
      out_data.retransmit_request <= resend;
      out_data.window_now         <= cwnd;
      out_data.threshold_now      <= ssthresh;
      out_data.duplicate_count    <= dup_cnt;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;
  // register writes only between events
  assign cfg.ready     = (state == ST_IDLE);

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_rtx_kind: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.retransmit_request) |->
      (results.data.event_kind == EV_DUP_ACK))
    else $error("retransmit on a non-duplicate event");

  a_rtx_count: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.retransmit_request) |->
      (results.data.duplicate_count == DUP_FAST))
    else $error("retransmit off the third duplicate");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_DIV))
    else $error("divider running outside its state");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the TCP Reno congestion window unit, scoreboard class inside.
module tb;
  import tcrw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_TAIL  = 48;
  localparam int unsigned ACK_CEIL    = 32'h3FF0_0000;

  class window_tracker;
    logic [15:0] seg;
    logic [31:0] cwnd;
    logic [31:0] thresh;
    logic [31:0] allow;
    logic [30:0] last_ack;
    logic [7:0]  dups;
    bit          in_recovery;
    result_t     pending_reports[$];
    int          mismatches;
    int          checked;
    int          resends;
    int          kind_count[4];

    function new();
      seg         = SEG_SIZE_RST;
      cwnd        = {16'd0, SEG_SIZE_RST};
      allow       = {16'd0, SEG_SIZE_RST};
      thresh      = INIT_THR_RST;
      last_ack    = '0;
      dups        = '0;
      in_recovery = 1'b0;
    endfunction

    function logic [31:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function logic [31:0] floor_diff(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
    endfunction

    function logic [31:0] backoff();
      logic [31:0] half;
      logic [31:0] two_seg;
      half    = cwnd >> 1;
      two_seg = {15'd0, seg, 1'b0};
      return (half > two_seg) ? half : two_seg;
    endfunction

    function void load_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SEGMENT_SIZE: begin
          seg   = v[15:0];
          cwnd  = {16'd0, v[15:0]};
          allow = {16'd0, v[15:0]};
        end
        REG_INITIAL_THRESHOLD: begin
          thresh = v;
        end
        default: ;
      endcase
    endfunction

    function void absorb_event(event_t e);
      result_t     r;
      bit          slow;
      logic [63:0] sq;
      logic [63:0] grow;
      r = '0;
      if (e.operation == OP_TIMEOUT) begin
        r.event_kind = EV_TIMEOUT;
        allow  = {16'd0, seg};
        thresh = backoff();
        cwnd   = {16'd0, seg};
      end else if (e.ack_number > last_ack) begin
        r.event_kind = EV_NEW_ACK;
        slow     = cwnd < thresh;
        dups     = '0;
        last_ack = e.ack_number;
        if (in_recovery) begin
          cwnd        = thresh;
          in_recovery = 1'b0;
        end else if (slow) begin
          cwnd = sat_sum({32'd0, cwnd}, {48'd0, seg});
        end else begin
          sq   = {48'd0, seg} * {48'd0, seg};
          grow = (cwnd != 0) ? sq / cwnd : sq;
          cwnd = sat_sum({32'd0, cwnd}, grow);
        end
        allow = floor_diff(cwnd, e.outstanding_bytes);
      end else if (e.ack_number == last_ack) begin
        r.event_kind = EV_DUP_ACK;
        if (dups != DUP_MAX) dups = dups + 8'd1;
        if (dups == DUP_FAST && e.outstanding_bytes != 0) begin
          in_recovery = 1'b1;
          thresh      = backoff();
          cwnd        = sat_sum({32'd0, thresh}, {48'd0, seg} * 64'd3);
          allow       = floor_diff(floor_diff(cwnd, e.outstanding_bytes),
                                   {16'd0, e.head_segment_size});
          r.retransmit_request = 1'b1;
        end
      end else begin
        r.event_kind = EV_STALE_ACK;
      end
      r.send_allowance  = allow;
      r.window_now      = cwnd;
      r.threshold_now   = thresh;
      r.duplicate_count = dups;
      pending_reports.push_back(r);
    endfunction

    function void compare_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: kind=%0d allow=%0h rtx=%0b cwnd=%0h thr=%0h dup=%0d",
                   got.event_kind, got.send_allowance, got.retransmit_request,
                   got.window_now, got.threshold_now, got.duplicate_count);
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      kind_count[got.event_kind]++;
      if (got.retransmit_request) resends++;
      if (got.event_kind !== want.event_kind ||
          got.send_allowance !== want.send_allowance ||
          got.retransmit_request !== want.retransmit_request ||
          got.window_now !== want.window_now ||
          got.threshold_now !== want.threshold_now ||
          got.duplicate_count !== want.duplicate_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on report %0d", checked);
          $display("  want kind=%0d allow=%0h rtx=%0b cwnd=%0h thr=%0h dup=%0d",
                   want.event_kind, want.send_allowance, want.retransmit_request,
                   want.window_now, want.threshold_now, want.duplicate_count);
          $display("  got  kind=%0d allow=%0h rtx=%0b cwnd=%0h thr=%0h dup=%0d",
                   got.event_kind, got.send_allowance, got.retransmit_request,
                   got.window_now, got.threshold_now, got.duplicate_count);
        end
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tcrw_event_if  ev_if();
  tcrw_result_if res_if();
  tcrw_cfg_if    cfg_if();

  tcp_reno_congestion_window_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  window_tracker board;
  int unsigned   cycles;
  int            sent;
  int            reg_writes;
  int            burst_left;
  bit            offering;
  int            hold_asks;
  int            hold_seen;
  int            hold_left;
  int            rx_mode;
  int            rx_left;
  int unsigned   rx_phase;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, board.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: ready follows a randomly chosen pattern that is redrawn when its run ends, plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) board.compare_report(res_if.data);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 400);
      end else begin
        rx_left--;
      end
      rx_phase++;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = $urandom_range(150, 400);
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= ((rx_phase % 8) >= 3);
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic event_t make_event(op_t op, logic [30:0] ack, logic [31:0] queued,
                                        logic [15:0] head);
    event_t e;
    e.operation         = op;
    e.ack_number        = ack;
    e.outstanding_bytes = queued;
    e.head_segment_size = head;
    return e;
  endfunction

  function automatic logic [31:0] pick_bytes();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, board.cwnd);
    endcase
  endfunction

  function automatic logic [15:0] pick_head();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [30:0] next_ack();
    int unsigned step;
    int unsigned last;
    last = {1'b0, board.last_ack};
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 22) : $urandom_range(1, 4000);
    if (last + step > ACK_CEIL) return last[30:0];
    return 31'(last + step);
  endfunction

  function automatic logic [30:0] stale_ack();
    if (board.last_ack == 0) return '0;
    return 31'($urandom_range(0, board.last_ack - 1));
  endfunction

  task automatic issue(input event_t e);
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    ev_if.data  <= e;
    ev_if.valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!ev_if.ready);
    board.absorb_event(e);
    sent++;
    if ($urandom_range(0, 199) == 0) hold_asks++;
    burst_left--;
    if (burst_left == 0) begin
      ev_if.valid <= 1'b0;
      offering = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 45) : $urandom_range(1, 12))
        @(posedge clk);
    end
  endtask

  task automatic drain();
    if (offering) begin
      ev_if.valid <= 1'b0;
      offering   = 1'b0;
      burst_left = 0;
      @(posedge clk);
    end
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    cfg_word_t w;
    drain();
    w.index = idx;
    w.value = v;
    cfg_if.data  <= w;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.load_reg(idx, v);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic directed_run();
    issue(make_event(OP_ACK, 31'd0, 32'd0, 16'd0));
    issue(make_event(OP_TIMEOUT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    issue(make_event(OP_ACK, 31'd1460, 32'd0, 16'd0));
    issue(make_event(OP_ACK, 31'd2920, 32'd512, 16'd0));
    issue(make_event(OP_ACK, 31'd1000, 32'd0, 16'd0));
    issue(make_event(OP_ACK, 31'd2920, 32'hFFFF_FFFF, 16'd512));
    issue(make_event(OP_ACK, 31'd2920, 32'd100, 16'd512));
    // third duplicate with nothing queued
    issue(make_event(OP_ACK, 31'd2920, 32'd0, 16'd512));
    issue(make_event(OP_ACK, 31'd2920, 32'd100, 16'd512));
    issue(make_event(OP_ACK, 31'd4380, 32'd1000, 16'd0));
    issue(make_event(OP_ACK, 31'd4380, 32'd3000, 16'd1460));
    issue(make_event(OP_ACK, 31'd4380, 32'd3000, 16'd1460));
    issue(make_event(OP_ACK, 31'd4380, 32'd3000, 16'd1460));
    issue(make_event(OP_ACK, 31'd4380, 32'd10, 16'hFFFF));
    issue(make_event(OP_ACK, 31'd5840, 32'hFFFF_FFFF, 16'd0));
    issue(make_event(OP_ACK, 31'd7300, 32'd0, 16'hFFFF));
    issue(make_event(OP_TIMEOUT, 31'd0, 32'd0, 16'd0));
    issue(make_event(OP_ACK, 31'd8760, 32'd1, 16'd0));
    issue(make_event(OP_ACK, 31'd8760, 32'd1, 16'hFFFF));
    issue(make_event(OP_ACK, 31'd8760, 32'd1, 16'hFFFF));
    issue(make_event(OP_ACK, 31'd8760, 32'd1, 16'hFFFF));
    issue(make_event(OP_ACK, 31'd10220, 32'd2000, 16'd0));
  endtask

  task automatic random_traffic(input int n);
    int target;
    int k;
    target = sent + n;
    while (sent < target) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        issue(make_event(OP_ACK, next_ack(), pick_bytes(), pick_head()));
      end else if (k < 68) begin
        // duplicate run, then the recovering ack
        repeat ($urandom_range(2, 5))
          issue(make_event(OP_ACK, board.last_ack, pick_bytes(), pick_head()));
        issue(make_event(OP_ACK, next_ack(), pick_bytes(), pick_head()));
      end else if (k < 78) begin
        issue(make_event(OP_TIMEOUT, 31'($urandom), $urandom, pick_head()));
      end else if (k < 88) begin
        issue(make_event(OP_ACK, stale_ack(), $urandom, pick_head()));
      end else begin
        issue(make_event(OP_ACK, board.last_ack, pick_bytes(), pick_head()));
      end
    end
  endtask

  task automatic dup_storm(input int n);
    issue(make_event(OP_ACK, next_ack(), pick_bytes(), pick_head()));
    repeat (n) issue(make_event(OP_ACK, board.last_ack, pick_bytes(), pick_head()));
    issue(make_event(OP_ACK, next_ack(), pick_bytes(), pick_head()));
  endtask

  // recovery exit loads the threshold register value, then growth saturates
  task automatic saturation_run();
    write_reg(REG_SEGMENT_SIZE, 32'd65535);
    issue(make_event(OP_ACK, next_ack(), 32'd0, 16'd0));
    repeat (3) issue(make_event(OP_ACK, board.last_ack, 32'd1000, 16'd1460));
    write_reg(REG_INITIAL_THRESHOLD, 32'hFFFF_FFF0);
    issue(make_event(OP_ACK, next_ack(), 32'd0, 16'd0));
    write_reg(REG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
    issue(make_event(OP_ACK, next_ack(), 32'd0, 16'd0));
    issue(make_event(OP_ACK, next_ack(), 32'hFFFF_FFFF, 16'd0));
    repeat (3) issue(make_event(OP_ACK, board.last_ack, 32'hFFFF_FFFF, 16'hFFFF));
    issue(make_event(OP_ACK, next_ack(), 32'd0, 16'd0));
    issue(make_event(OP_TIMEOUT, 31'($urandom), $urandom, 16'd0));
  endtask

  // top of the ack space; nothing after this can be a new ack
  task automatic top_ack_run();
    issue(make_event(OP_ACK, 31'(32'h4000_0000 + $urandom_range(0, 1 << 20)), 32'd0, 16'd0));
    issue(make_event(OP_ACK, 31'h7FFF_FFFE, $urandom, 16'd0));
    issue(make_event(OP_ACK, 31'h7FFF_FFFF, 32'd0, 16'd0));
    repeat (3) issue(make_event(OP_ACK, 31'h7FFF_FFFF, pick_bytes(), pick_head()));
    issue(make_event(OP_ACK, 31'd0, 32'd0, 16'd0));
    issue(make_event(OP_TIMEOUT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    issue(make_event(OP_ACK, 31'h7FFF_FFFF, 32'd5, 16'd5));
  endtask

  initial begin
    int fails;
    board = new();
    rst          <= 1'b1;
    ev_if.valid  <= 1'b0;
    ev_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed_run();
    hold_asks++;
    random_traffic(110);

    write_reg(REG_SEGMENT_SIZE, 32'd1);
    write_reg(REG_INITIAL_THRESHOLD, 32'd1);
    random_traffic(90);
    dup_storm(258);

    write_reg(REG_SEGMENT_SIZE, 32'd65535);
    write_reg(REG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
    random_traffic(80);

    write_reg(REG_SEGMENT_SIZE, 32'd1460);
    write_reg(REG_INITIAL_THRESHOLD, $urandom_range(1, 32'hFFFF_FFFF));
    random_traffic(80);

    write_reg(REG_SEGMENT_SIZE, 32'd536);
    write_reg(REG_INITIAL_THRESHOLD, 32'd4288);
    random_traffic(70);

    repeat (2) begin
      write_reg(REG_SEGMENT_SIZE, $urandom_range(1, 65535));
      write_reg(REG_INITIAL_THRESHOLD, $urandom_range(1, 1 << 20));
      random_traffic(35);
    end

    saturation_run();
    top_ack_run();

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    fails = board.mismatches + board.pending();
    $display("%0d events sent, %0d reports checked, %0d register writes, %0d retransmits",
             sent, board.checked, reg_writes, board.resends);
    $display("reports by kind: new %0d, duplicate %0d, stale %0d, timeout %0d",
             board.kind_count[EV_NEW_ACK], board.kind_count[EV_DUP_ACK],
             board.kind_count[EV_STALE_ACK], board.kind_count[EV_TIMEOUT]);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", board.mismatches, board.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tcrw_pkg.sv
src/tcrw_event_if.sv
src/tcrw_result_if.sv
src/tcrw_cfg_if.sv
src/tcrw_div.sv
src/tcp_reno_congestion_window_unit.sv
test/tb.sv
